// ===== hdl/bli_pkg.sv =====
// bli_pkg: shared types and codes of the bounded list block
// used by bli_cell, bli_or_tree and bounded_list_insert_delete
// no dependencies
`default_nettype none

package bli_pkg;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_DEL_FRONT = 3'd1,
    CMD_DEL_BACK  = 3'd2,
    CMD_DEL_POS   = 3'd3,
    CMD_DEL_MID   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  localparam int unsigned ValW = 32;

  // one command transfer
  typedef struct packed {
    logic [2:0]             command;
    logic signed [ValW-1:0] new_value;
    logic [8:0]             position;
  } cmd_t;

  // one result transfer
  typedef struct packed {
    logic [1:0]             status;
    logic [8:0]             length;
    logic signed [ValW-1:0] removed_value;
  } res_t;

  // broadcast control into the cell chain
  typedef struct packed {
    logic                   ins;
    logic                   del;
    logic signed [ValW-1:0] new_value;
  } ctl_t;

endpackage

`default_nettype wire

// ===== hdl/bli_cell.sv =====
// bli_cell: one list entry of the shifting chain
// depends on bli_pkg
`default_nettype none

module bli_cell #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned IDX   = 0
) (
  input  wire logic                                clk_i,
  input  wire bli_pkg::ctl_t                       ctl_i,
  input  wire logic [$clog2(DEPTH)-1:0]            del_idx_i,
  input  wire logic signed [bli_pkg::ValW-1:0]     left_i,
  input  wire logic signed [bli_pkg::ValW-1:0]     right_i,
  output logic signed [bli_pkg::ValW-1:0]          data_o,
  output logic signed [bli_pkg::ValW-1:0]          hit_o
);
  import bli_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam logic [IW-1:0] MyIdx = IW'(IDX);

  logic signed [ValW-1:0] data_q, data_d;
  logic signed [ValW-1:0] hit_q, hit_d;
  logic                   hit;

  assign hit = ctl_i.del && (del_idx_i == MyIdx);

  always_comb begin
    data_d = data_q;
    if (ctl_i.ins) begin
      data_d = (IDX == 0) ? ctl_i.new_value : left_i;
    end else if (ctl_i.del && (MyIdx >= del_idx_i)) begin
      // close the gap: take the entry behind
      data_d = right_i;
    end
    hit_d = hit ? data_q : '0;
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    hit_q  <= hit_d;
  end

  assign data_o = data_q;
  assign hit_o  = hit_q;

endmodule

`default_nettype wire

// ===== hdl/bli_or_tree.sv =====
// bli_or_tree: pipelined or-reduction of the cells' masked hit values
// depends on bli_pkg
`default_nettype none

module bli_or_tree #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                                    clk_i,
  input  wire logic [DEPTH-1:0][bli_pkg::ValW-1:0]     leaf_i,
  output logic [bli_pkg::ValW-1:0]                     root_o
);
  import bli_pkg::*;

  localparam int unsigned P = 2 ** $clog2(DEPTH);

  // heap order: node n has children 2n and 2n+1, leaves at P..2P-1
  logic [ValW-1:0] node_w [1:2*P-1];
  logic [ValW-1:0] node_q [1:P-1];

  for (genvar n = 1; n < P; n++) begin : g_node
    always_ff @(posedge clk_i) begin
      node_q[n] <= node_w[2*n] | node_w[2*n+1];
    end
    assign node_w[n] = node_q[n];
  end

  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < DEPTH) begin : g_used
      assign node_w[P+i] = leaf_i[i];
    end else begin : g_pad
      assign node_w[P+i] = '0;
    end
  end

  assign root_o = node_w[1];

endmodule

`default_nettype wire

// ===== hdl/bounded_list_insert_delete.sv =====
// bounded_list_insert_delete: ordered list of signed values in a chain of cells
// depends on bli_pkg, bli_cell, bli_or_tree
// throughput: one command per cycle, busy stays low; the result reaches done_o through
// the cells' hit register and then the 8 levels of the or tree (for DEPTH 256)
// the shift and the new count settle in the accepting cycle; the or tree that
// gathers the removed value sets the latency; the receiver cannot stall
// reset clears the entry count and the result valid bits; entry data is not reset
`default_nettype none

module bounded_list_insert_delete #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  input  wire bli_pkg::cmd_t  cmd_i,
  output logic                busy,
  output logic                done_o,
  output bli_pkg::res_t       res_o
);
  import bli_pkg::*;

  localparam int unsigned IW  = $clog2(DEPTH);
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned LVL = $clog2(DEPTH);
  localparam int unsigned MW  = (CW > 9) ? CW : 9;

  // entry count and command decode
  logic [CW-1:0] count_q, count_d;
  logic          accept;
  ctl_t          ctl;
  logic [IW-1:0] del_idx;
  status_e       status;
  logic [MW-1:0] pos_x, cnt_x;
  logic          empty, full;

  assign busy   = 1'b0;   // the block never holds off a command
  assign accept = start && !busy;
  assign empty  = (count_q == '0);
  assign full   = (count_q == CW'(DEPTH));
  assign pos_x  = MW'(cmd_i.position);
  assign cnt_x  = MW'(count_q);

  always_comb begin
    ctl.ins       = 1'b0;
    ctl.del       = 1'b0;
    ctl.new_value = cmd_i.new_value;
    del_idx       = '0;
    status        = ST_OK;
    count_d       = count_q;
    if (accept) begin
      unique case (cmd_e'(cmd_i.command))
        CMD_INS_FRONT: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            ctl.ins = 1'b1;
            count_d = count_q + CW'(1);
          end
        end
        CMD_DEL_FRONT: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            ctl.del = 1'b1;
            del_idx = '0;
          end
        end
        CMD_DEL_BACK: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            ctl.del = 1'b1;
            del_idx = IW'(count_q - CW'(1));
          end
        end
        CMD_DEL_POS: begin
          if (empty) begin
            status = ST_EMPTY;
          end else if ((pos_x == '0) || (pos_x > cnt_x)) begin
            status = ST_BADPOS;
          end else begin
            ctl.del = 1'b1;
            del_idx = IW'(cmd_i.position - 9'd1);
          end
        end
        CMD_DEL_MID: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            ctl.del = 1'b1;
            del_idx = IW'(count_q >> 1);
          end
        end
        default: begin
          // unused command codes leave the list alone
        end
      endcase
      if (ctl.del) begin
        count_d = count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // chain of cells, cell 0 is the front
  logic [DEPTH-1:0][ValW-1:0] data_w;
  logic [DEPTH-1:0][ValW-1:0] hit_w;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [ValW-1:0] left, right;
    if (i == 0) begin : g_front
      assign left = '0;
    end else begin : g_left
      assign left = data_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_back
      assign right = '0;
    end else begin : g_right
      assign right = data_w[i+1];
    end
    bli_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .del_idx_i (del_idx),
      .left_i    (left),
      .right_i   (right),
      .data_o    (data_w[i]),
      .hit_o     (hit_w[i])
    );
  end

  // gather the removed value; only the hit cell holds a nonzero mask
  logic [ValW-1:0] removed;

  bli_or_tree #(
    .DEPTH (DEPTH)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (hit_w),
    .root_o (removed)
  );

  // status and length ride alongside the tree levels
  logic          vld_q [0:LVL];
  logic [1:0]    st_q  [0:LVL];
  logic [8:0]    len_q [0:LVL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= LVL; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      vld_q[0] <= accept;
      for (int k = 1; k <= LVL; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0]  <= status;
    len_q[0] <= 9'(count_d);
    for (int k = 1; k <= LVL; k++) begin
      st_q[k]  <= st_q[k-1];
      len_q[k] <= len_q[k-1];
    end
  end

  assign done_o              = vld_q[LVL];
  assign res_o.status        = st_q[LVL];
  assign res_o.length        = len_q[LVL];
  assign res_o.removed_value = removed;

  // count never leaves its range
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  // an accepted insert on a list with room grows it by one
  a_ins_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i.command == CMD_INS_FRONT) && !full)
      |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow the list");

  // every transfer in gives one result once it has passed the hit register and the or tree
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(LVL+1) done_o)
    else $error("result strobe missing");

  // a refused or empty command removes nothing
  a_zero_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.status != ST_OK)) |-> (res_o.removed_value == '0))
    else $error("value removed on a failed command");

endmodule

`default_nettype wire

// ===== sim/tb_bounded_list_insert_delete.sv =====
// tb_bounded_list_insert_delete: self-checking bench for the bounded list block
// depends on bli_pkg and bounded_list_insert_delete; a queue-based list predicts each result
// directed tests on empty and full lists, value and position extremes, then a phased random run
`default_nettype none

module tb_bounded_list_insert_delete;
  timeunit 1ns;
  timeprecision 1ps;

  import bli_pkg::*;

  localparam int unsigned DEPTH      = 256;
  localparam int unsigned LATENCY    = $clog2(DEPTH) + 1;
  localparam int unsigned RAND_ITEMS = 1200;
  localparam int unsigned PHASE_LEN  = 240;  // random items per traffic phase
  localparam int unsigned CALM_TAIL  = 200;  // last random items sent back to back
  localparam int unsigned STALL_MAX  = 1000; // cycles with no transfer before giving up
  localparam int unsigned MAX_SHOWN  = 10;

  // command codes the block ignores
  localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;

  logic  clk_i;
  logic  rst_ni;
  logic  start;
  cmd_t  cmd_i;
  logic  busy;
  logic  done_o;
  res_t  res_o;

  bounded_list_insert_delete #(
    .DEPTH (DEPTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .busy   (busy),
    .done_o (done_o),
    .res_o  (res_o)
  );

  // 8 ns clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // list predictor: front of the queue is the front of the list
  // ---------------------------------------------------------------------------
  logic signed [ValW-1:0] list_model_q[$];
  res_t                   pending_res_q[$];

  int unsigned accepted_cnt;
  int unsigned checked_cnt;
  int unsigned mismatch_cnt;
  int unsigned stall_cnt;
  int unsigned peak_len;
  int unsigned status_cnt[4];

  // applies one command to the predicted list and returns the result it must produce
  function automatic res_t apply_list_cmd(cmd_t c);
    res_t        r;
    int unsigned n;
    int unsigned idx;
    r      = '0;
    r.status = ST_OK;
    n      = list_model_q.size();
    case (c.command)
      CMD_INS_FRONT: begin
        if (n >= DEPTH) r.status = ST_FULL;
        else list_model_q.push_front(c.new_value);
      end
      CMD_DEL_FRONT: begin
        if (n == 0) r.status = ST_EMPTY;
        else r.removed_value = list_model_q.pop_front();
      end
      CMD_DEL_BACK: begin
        if (n == 0) r.status = ST_EMPTY;
        else r.removed_value = list_model_q.pop_back();
      end
      CMD_DEL_POS: begin
        // empty wins over a bad position
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else if (c.position == 0 || c.position > n) begin
          r.status = ST_BADPOS;
        end else begin
          idx             = c.position - 1;
          r.removed_value = list_model_q[idx];
          list_model_q.delete(idx);
        end
      end
      CMD_DEL_MID: begin
        // middle is index floor(n/2), so a single entry is removed too
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          idx             = n / 2;
          r.removed_value = list_model_q[idx];
          list_model_q.delete(idx);
        end
      end
      default: ; // unused codes leave the list alone
    endcase
    r.length = 9'(list_model_q.size());
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker and command monitor, both sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_res_q.size() == 0) begin
          // result transfer with nothing outstanding
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_SHOWN)
            $display("%0t: unexpected result status %0d length %0d removed %0d",
                     $realtime, res_o.status, res_o.length, res_o.removed_value);
        end else begin
          want = pending_res_q.pop_front();
          checked_cnt++;
          status_cnt[want.status]++;
          if (res_o.status !== want.status || res_o.length !== want.length ||
              res_o.removed_value !== want.removed_value) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_SHOWN)
              $display("%0t: result %0d mismatch: exp st %0d len %0d rm %0d, got st %0d len %0d rm %0d",
                       $realtime, checked_cnt, want.status, want.length, want.removed_value,
                       res_o.status, res_o.length, res_o.removed_value);
          end
        end
      end
      // command transfer: predict from the state after all earlier commands
      if (start && !busy) begin
        pending_res_q.push_back(apply_list_cmd(cmd_i));
        accepted_cnt++;
        if (list_model_q.size() > peak_len) peak_len = list_model_q.size();
      end
    end
  end

  // watchdog on cycles with no transfer in either direction
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_MAX) begin
      $display("%0t: no transfer for %0d cycles", $realtime, STALL_MAX);
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers; every task starts and ends on a falling edge
  // ---------------------------------------------------------------------------

  // one command transfer, start stays high for a following send
  task automatic send_cmd(logic [2:0] code, logic signed [ValW-1:0] value, logic [8:0] pos);
    int unsigned seen;
    cmd_t        c;
    seen        = accepted_cnt;
    c.command   = code;
    c.new_value = value;
    c.position  = pos;
    start      <= 1'b1;
    cmd_i      <= c;
    do @(negedge clk_i); while (accepted_cnt == seen);
  endtask

  task automatic idle_for(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // hold off until every outstanding result has come back
  task automatic wait_results_drained();
    start <= 1'b0;
    do @(negedge clk_i); while (pending_res_q.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // test tasks
  // ---------------------------------------------------------------------------

  // every delete on an empty list, empty checked before position, unused codes
  task automatic test_empty_list();
    send_cmd(CMD_DEL_FRONT, '0, '0);
    send_cmd(CMD_DEL_BACK,  '0, '0);
    send_cmd(CMD_DEL_POS,   '0, 9'd0);
    send_cmd(CMD_DEL_POS,   '0, 9'h1FF);
    send_cmd(CMD_DEL_MID,   '0, '0);
    for (int c = CMD_RSVD_FIRST; c <= CMD_RSVD_LAST; c++)
      send_cmd(3'(c), 32'hFFFF_FFFF, 9'h1FF);
  endtask

  // value extremes through insert and each delete flavor
  task automatic test_value_extremes();
    send_cmd(CMD_INS_FRONT, 32'sh8000_0000, '0);
    send_cmd(CMD_DEL_MID,   '0, '0);              // middle of a single entry
    send_cmd(CMD_INS_FRONT, 32'sh7FFF_FFFF, '0);
    send_cmd(CMD_INS_FRONT, 32'sh8000_0000, '0);
    send_cmd(CMD_INS_FRONT, -32'sd1, '0);
    send_cmd(CMD_INS_FRONT, 32'sd0, '0);
    send_cmd(CMD_INS_FRONT, 32'sd1, '0);
    send_cmd(CMD_DEL_POS,   '0, 9'd0);            // position zero
    send_cmd(CMD_DEL_POS,   '0, 9'd6);            // one past the count
    send_cmd(CMD_DEL_POS,   '0, 9'd5);            // last entry by position
    send_cmd(CMD_DEL_POS,   '0, 9'd1);            // first entry by position
    send_cmd(CMD_DEL_MID,   '0, '0);
    send_cmd(CMD_RSVD_FIRST, 32'sd7, 9'd1);       // ignored with entries present
    send_cmd(CMD_DEL_BACK,  '0, '0);
    send_cmd(CMD_DEL_FRONT, '0, '0);
  endtask

  // fill to capacity, refuse inserts, delete at the top position
  task automatic test_full_list();
    while (list_model_q.size() < DEPTH)
      send_cmd(CMD_INS_FRONT, $urandom(), '0);
    send_cmd(CMD_INS_FRONT, $urandom(), '0);
    send_cmd(CMD_INS_FRONT, 32'sh7FFF_FFFF, '0);
    send_cmd(CMD_DEL_POS,   '0, 9'(DEPTH + 1));   // beyond count on a full list
    send_cmd(CMD_DEL_POS,   '0, 9'(DEPTH));       // back entry, position bit 8 set
    send_cmd(CMD_INS_FRONT, 32'sh1234_5678, '0);  // full again
    send_cmd(CMD_DEL_MID,   '0, '0);
    send_cmd(CMD_DEL_BACK,  '0, '0);
  endtask

  // phased random traffic: growth, shrink and balanced stretches, some noise
  task automatic test_random_traffic();
    int unsigned insert_pct;
    int unsigned n;
    logic [2:0]  code;
    logic signed [ValW-1:0] value;
    logic [8:0]  pos;
    for (int unsigned i = 0; i < RAND_ITEMS; i++) begin
      case ((i / PHASE_LEN) % 5)
        0: insert_pct = 95;
        1: insert_pct = 8;
        2: insert_pct = 50;
        3: insert_pct = 92;
        default: insert_pct = 5;
      endcase
      n     = list_model_q.size();
      value = $urandom();
      if ($urandom_range(0, 7) == 0)
        value = ($urandom_range(0, 1) == 0) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      if ($urandom_range(0, 9) == 0) begin
        // noise: any code, any position
        code = 3'($urandom_range(0, 7));
        pos  = 9'($urandom_range(0, 511));
      end else if ($urandom_range(0, 99) < insert_pct) begin
        code = CMD_INS_FRONT;
        pos  = 9'($urandom_range(0, 511));
      end else begin
        case ($urandom_range(0, 3))
          0: code = CMD_DEL_FRONT;
          1: code = CMD_DEL_BACK;
          2: code = CMD_DEL_POS;
          default: code = CMD_DEL_MID;
        endcase
        pos = (n > 0) ? 9'($urandom_range(1, n)) : 9'($urandom_range(0, 511));
      end

      // sender gaps in bursts, with quiet stretches and none near the end
      if (i < RAND_ITEMS - CALM_TAIL && (i / 50) % 3 != 0 && $urandom_range(0, 5) == 0)
        idle_for($urandom_range(1, 10));

      // one full pause mid-run until every result is back
      if (i == RAND_ITEMS / 2) wait_results_drained();

      send_cmd(code, value, pos);
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    cmd_i        = '0;
    accepted_cnt = 0;
    checked_cnt  = 0;
    mismatch_cnt = 0;
    stall_cnt    = 0;
    peak_len     = 0;
    for (int s = 0; s < 4; s++) status_cnt[s] = 0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_list();
    test_value_extremes();
    test_full_list();
    wait_results_drained();
    test_random_traffic();

    // let the pipeline run dry, then watch for stray results
    wait_results_drained();
    repeat (4 * LATENCY) @(negedge clk_i);

    $display("covered %0d commands, %0d results checked, peak list length %0d of %0d",
             accepted_cnt, checked_cnt, peak_len, DEPTH);
    $display("status mix: ok %0d, empty %0d, bad position %0d, full %0d; mismatches %0d",
             status_cnt[ST_OK], status_cnt[ST_EMPTY], status_cnt[ST_BADPOS],
             status_cnt[ST_FULL], mismatch_cnt);
    if (mismatch_cnt == 0 && pending_res_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/bli_pkg.sv
hdl/bli_cell.sv
hdl/bli_or_tree.sv
hdl/bounded_list_insert_delete.sv
sim/tb_bounded_list_insert_delete.sv
